/* hw/rtl/rtpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpl_pkg: shared types and constants of the resonant lowpass cascade
// Sizes, register codes, sequencer states and the saturation helper.
// ----------------------------------------------------------------------------
package rtpl_pkg;

	localparam int STAGE_COUNT = 12;
	localparam int SAMPLE_BITS = 24;
	localparam int IDX_BITS    = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

	localparam int COEF_BITS  = 18;
	localparam int RES_BITS   = 17;
	localparam int COEF_FRAC  = 17;
	localparam int RES_FRAC   = 16;
	localparam int CFG_IDX_BITS = 1;

	localparam int TGT_BITS   = SAMPLE_BITS + 2;
	localparam int DIFF_BITS  = SAMPLE_BITS + 3;
	localparam int MULB_BITS  = COEF_BITS + 1;
	localparam int PROD_BITS  = DIFF_BITS + MULB_BITS;
	localparam int RND_BITS   = SAMPLE_BITS + 4;

	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
	localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(STAGE_COUNT - 1);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CUTOFF    = 1'b0,
		REG_RESONANCE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB_MUL,
		ST_FB_ADD,
		ST_STG_MUL,
		ST_STG_ADD,
		ST_DONE
	} state_t;

	typedef enum logic {
		FRAC_RES,
		FRAC_COEF
	} frac_t;

	typedef struct packed {
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
		logic                wr_en;
		logic [IDX_BITS-1:0] wr_addr;
	} ram_ctl_t;

	typedef struct packed {
		logic  issue;
		frac_t frac;
	} mac_ctl_t;

	typedef struct packed {
		state_t              state;
		logic [IDX_BITS-1:0] idx;
		logic                load;
	} seq_stat_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [RND_BITS-1:0] v
	);
		logic signed [RND_BITS-1:0] hi;
		logic signed [RND_BITS-1:0] lo;
		hi = RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - RND_BITS'(1);
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

/* hw/rtl/rtpl_stage_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpl_stage_ram: stage value memory
// One write and one read port, registered read data; entries read zero
// until first written after reset.
// ----------------------------------------------------------------------------
module rtpl_stage_ram (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rtpl_pkg::ram_ctl_t                     ctl,
	input  logic signed [rtpl_pkg::SAMPLE_BITS-1:0] wr_data,
	output logic signed [rtpl_pkg::SAMPLE_BITS-1:0] rd_data
);
	import rtpl_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem [STAGE_COUNT];
	logic [STAGE_COUNT-1:0]        valid_q;
	logic signed [SAMPLE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= valid_q[ctl.rd_addr] ? mem[ctl.rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/rtpl_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpl_mac: shared multiply and round unit
// Registers the product, then rounds half up by the selected fraction.
// ----------------------------------------------------------------------------
module rtpl_mac (
	input  logic                                  clk,
	input  rtpl_pkg::mac_ctl_t                    ctl,
	input  logic signed [rtpl_pkg::DIFF_BITS-1:0] a,
	input  logic [rtpl_pkg::COEF_BITS-1:0]        b,
	output logic signed [rtpl_pkg::RND_BITS-1:0]  rnd
);
	import rtpl_pkg::*;

	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] prod_s1;
	frac_t                       frac_s1;
	logic signed [PROD_BITS-1:0] sum;
	logic signed [PROD_BITS-1:0] shifted;

	assign prod = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= prod;
			frac_s1 <= ctl.frac;
		end
	end

	always_comb begin
		if (frac_s1 == FRAC_COEF) begin
			sum     = prod_s1 + (PROD_BITS'(1) <<< (COEF_FRAC - 1));
			shifted = sum >>> COEF_FRAC;
		end else begin
			sum     = prod_s1 + (PROD_BITS'(1) <<< (RES_FRAC - 1));
			shifted = sum >>> RES_FRAC;
		end
	end

	assign rnd = shifted[RND_BITS-1:0];

endmodule

/* hw/rtl/rtpl_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpl_seq: per-item sequencer and stage datapath
// Reads the last stage for feedback, then walks the stages, each one read,
// multiplied, rounded, saturated and written back.
// ----------------------------------------------------------------------------
module rtpl_seq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [rtpl_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic [rtpl_pkg::COEF_BITS-1:0]          coef,
	input  logic [rtpl_pkg::RES_BITS-1:0]           res_gain,
	input  logic                                    out_free,
	output logic signed [rtpl_pkg::SAMPLE_BITS-1:0] result,
	output rtpl_pkg::seq_stat_t                     stat,
	output rtpl_pkg::ram_ctl_t                      ram_ctl,
	output logic signed [rtpl_pkg::SAMPLE_BITS-1:0] ram_wr_data,
	input  logic signed [rtpl_pkg::SAMPLE_BITS-1:0] ram_rd_data,
	output rtpl_pkg::mac_ctl_t                      mac_ctl,
	output logic signed [rtpl_pkg::DIFF_BITS-1:0]   mac_a,
	output logic [rtpl_pkg::COEF_BITS-1:0]          mac_b,
	input  logic signed [rtpl_pkg::RND_BITS-1:0]    mac_rnd
);
	import rtpl_pkg::*;

	state_t                        state_q;
	state_t                        state_d;
	logic [IDX_BITS-1:0]           idx_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [TGT_BITS-1:0]    target_q;
	logic signed [SAMPLE_BITS-1:0] new_val;
	logic                          accept;
	logic                          last;
	logic                          load;

	assign accept  = in_valid && (state_q == ST_IDLE);
	assign last    = (idx_q == LAST_IDX);
	assign new_val = sat_sample(RND_BITS'(s_q) + mac_rnd);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FB_MUL;
				end
			end
			ST_FB_MUL:  state_d = ST_FB_ADD;
			ST_FB_ADD:  state_d = ST_STG_MUL;
			ST_STG_MUL: state_d = ST_STG_ADD;
			ST_STG_ADD: begin
				if (!last) begin
					state_d = ST_STG_MUL;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		ram_ctl         = '0;
		mac_ctl.issue   = 1'b0;
		mac_ctl.frac    = FRAC_COEF;
		mac_a           = DIFF_BITS'(target_q) - DIFF_BITS'(ram_rd_data);
		mac_b           = coef;
		load            = 1'b0;
		result          = new_val;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = LAST_IDX;
				end
			end
			ST_FB_MUL: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.frac  = FRAC_RES;
				mac_a         = DIFF_BITS'(ram_rd_data);
				mac_b         = COEF_BITS'(res_gain);
			end
			ST_FB_ADD: begin
				ram_ctl.rd_en   = 1'b1;
				ram_ctl.rd_addr = '0;
			end
			ST_STG_MUL: begin
				mac_ctl.issue = 1'b1;
			end
			ST_STG_ADD: begin
				ram_ctl.wr_en   = 1'b1;
				ram_ctl.wr_addr = idx_q;
				if (!last) begin
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = IDX_BITS'(idx_q + 1'b1);
				end else begin
					load = out_free;
				end
			end
			ST_DONE: begin
				load   = out_free;
				result = target_q[SAMPLE_BITS-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FB_ADD) begin
				idx_q <= '0;
			end else if (state_q == ST_STG_ADD && !last) begin
				idx_q <= IDX_BITS'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= in_sample;
		end
		if (state_q == ST_STG_MUL) begin
			s_q <= ram_rd_data;
		end
		if (state_q == ST_FB_ADD) begin
			target_q <= TGT_BITS'(RND_BITS'(x_q) - mac_rnd);
		end else if (state_q == ST_STG_ADD) begin
			target_q <= TGT_BITS'(new_val);
		end
	end

	assign ram_wr_data = new_val;
	assign stat.state  = state_q;
	assign stat.idx    = idx_q;
	assign stat.load   = load;

endmodule

/* hw/rtl/resonant_twelve_pole_lowpass_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonant_twelve_pole_lowpass_core: resonant cascade of one-pole lowpasses
// One shared multiplier serves the feedback term, then each stage in turn;
// a new item is taken only when the last one is done and its result is in
// the output register. Reset clears the control and configuration registers;
// stage values read as zero until written.
// ----------------------------------------------------------------------------
module resonant_twelve_pole_lowpass_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic [rtpl_pkg::SAMPLE_BITS-1:0]         s_axis_tdata,  // [23:0] sample_in
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [rtpl_pkg::SAMPLE_BITS-1:0]         m_axis_tdata,  // [23:0] sample_out
	input  logic                                     cfg_wen,
	input  logic [rtpl_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [rtpl_pkg::COEF_BITS-1:0]           cfg_wdata
);
	import rtpl_pkg::*;

	logic [COEF_BITS-1:0]          coef_q;
	logic [RES_BITS-1:0]           res_q;
	logic [COEF_BITS-1:0]          coef_clamp;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_data_q;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] result;
	seq_stat_t                     stat;
	ram_ctl_t                      ram_ctl;
	logic signed [SAMPLE_BITS-1:0] ram_wr_data;
	logic signed [SAMPLE_BITS-1:0] ram_rd_data;
	mac_ctl_t                      mac_ctl;
	logic signed [DIFF_BITS-1:0]   mac_a;
	logic [COEF_BITS-1:0]          mac_b;
	logic signed [RND_BITS-1:0]    mac_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			res_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CUTOFF:    coef_q <= cfg_wdata;
				REG_RESONANCE: res_q  <= cfg_wdata[RES_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign coef_clamp = (coef_q > COEF_ONE) ? COEF_ONE : coef_q;
	assign out_free   = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.load) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	rtpl_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   ($signed(s_axis_tdata)),
		.coef        (coef_clamp),
		.res_gain    (res_q),
		.out_free    (out_free),
		.result      (result),
		.stat        (stat),
		.ram_ctl     (ram_ctl),
		.ram_wr_data (ram_wr_data),
		.ram_rd_data (ram_rd_data),
		.mac_ctl     (mac_ctl),
		.mac_a       (mac_a),
		.mac_b       (mac_b),
		.mac_rnd     (mac_rnd)
	);

	rtpl_stage_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ram_ctl),
		.wr_data (ram_wr_data),
		.rd_data (ram_rd_data)
	);

	rtpl_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.rnd (mac_rnd)
	);

	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> (stat.idx == LAST_IDX))
		else $error("result loaded before the last stage");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("new item taken while one is in work");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_ctl.wr_en && ram_ctl.rd_en) |-> (ram_ctl.wr_addr != ram_ctl.rd_addr))
		else $error("stage memory read and write hit the same entry");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwrote a waiting item");

endmodule
